FILE: hw/rtl/svad_pkg.sv
// svad_pkg: shared constants, types and twiddle tables for the band energy vad
// no dependencies; imported by every module of the block
package svad_pkg;

	localparam int FRAME_SAMPLES  = 512;
	localparam int HISTORY_FRAMES = 16;
	localparam int ENERGY_BITS    = 48;

	localparam int IDX_W   = $clog2(FRAME_SAMPLES);
	localparam int OCT_N   = FRAME_SAMPLES / 8;
	localparam int OCT_W   = IDX_W - 3;
	localparam int BIN_W   = 9;
	localparam int EN_W    = ENERGY_BITS;
	localparam int HIST_W  = $clog2(HISTORY_FRAMES);
	localparam int FILL_W  = HIST_W + 1;
	localparam int ACC_W   = IDX_W + 48;
	localparam int RQ_W    = ACC_W - 30;
	localparam int PROD_W  = 32 + RQ_W + 1;
	localparam int DIV_W   = EN_W + 1;
	localparam int DIV_BY  = 10;
	localparam int DIV_BIAS = 5;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 48;
	localparam int OUT_W   = 96;

	localparam logic [CFG_IW-1:0] REG_BAND_START = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BAND_END   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_INIT_THR   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_INIT_BG    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_HANGOVER   = 3'd4;
	localparam logic [CFG_IW-1:0] REG_WARMUP     = 3'd5;

	localparam logic [BIN_W-1:0] BAND_START_RST = 9'd4;
	localparam logic [BIN_W-1:0] BAND_END_RST   = 9'd48;
	localparam logic [EN_W-1:0]  THR_RST        = 48'd131072000;
	localparam logic [EN_W-1:0]  BG_RST         = 48'd0;
	localparam logic [7:0]       HANGOVER_RST   = 8'd6;
	localparam logic [7:0]       WARMUP_RST     = 8'd10;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned PI4_Q30 = 64'd843314857;

	typedef struct packed {
		logic [BIN_W-1:0] band_start;
		logic [BIN_W-1:0] band_end;
		logic [EN_W-1:0]  init_thr;
		logic [EN_W-1:0]  init_bg;
		logic [7:0]       hangover;
		logic [7:0]       warmup;
	} svad_cfg_t;

	typedef struct packed {
		logic             thr;
		logic             bg;
		logic [EN_W-1:0]  value;
	} svad_load_t;

	typedef struct packed {
		logic              frame_is_speech;
		logic              speech_active;
		logic              speech_began;
		logic              speech_ended;
		logic              forward_frame;
		logic [HIST_W-1:0] frame_slot;
		logic [HIST_W-1:0] replay_first_slot;
		logic [HIST_W-1:0] replay_count;
		logic [EN_W-1:0]   band_energy;
		logic [7:0]        silence_run;
		logic [15:0]       speech_run;
	} svad_res_t;

	typedef logic [30:0] oct_tab_t [0:OCT_N];

	function automatic longint unsigned taylor(longint unsigned x, bit want_sin);
		longint unsigned x2;
		longint unsigned t;
		x2 = (x * x) >> 30;
		if (want_sin) begin
			t = Q30_ONE - x2 / 72;
			t = Q30_ONE - ((x2 * t) >> 30) / 42;
			t = Q30_ONE - ((x2 * t) >> 30) / 20;
			t = Q30_ONE - ((x2 * t) >> 30) / 6;
			return (x * t) >> 30;
		end
		t = Q30_ONE - x2 / 90;
		t = Q30_ONE - ((x2 * t) >> 30) / 56;
		t = Q30_ONE - ((x2 * t) >> 30) / 30;
		t = Q30_ONE - ((x2 * t) >> 30) / 12;
		return Q30_ONE - ((x2 * t) >> 30) / 2;
	endfunction

	function automatic oct_tab_t build_oct(bit want_sin);
		oct_tab_t tab;
		longint unsigned x;
		for (int j = 0; j <= OCT_N; j++) begin
			x = (longint'(8 * j) * PI4_Q30) / FRAME_SAMPLES;
			tab[j] = 31'(taylor(x, want_sin));
		end
		return tab;
	endfunction

	localparam oct_tab_t COS_OCT = build_oct(1'b0);
	localparam oct_tab_t SIN_OCT = build_oct(1'b1);

	// q30 twiddle for table position p, folded from one octant
	function automatic logic signed [31:0] tw_lookup(logic [IDX_W-1:0] p, logic want_sin);
		logic [2:0]          oct;
		logic [OCT_W:0]      jj;
		logic signed [31:0]  c;
		logic signed [31:0]  s;
		logic signed [31:0]  ca;
		logic signed [31:0]  sa;
		logic signed [31:0]  r;
		oct = p[IDX_W-1 -: 3];
		jj = oct[0] ? ((OCT_W+1)'(OCT_N) - {1'b0, p[OCT_W-1:0]}) : {1'b0, p[OCT_W-1:0]};
		c = $signed({1'b0, COS_OCT[jj]});
		s = $signed({1'b0, SIN_OCT[jj]});
		ca = oct[0] ? s : c;
		sa = oct[0] ? c : s;
		case (oct[2:1])
			2'd0: r = want_sin ? sa : ca;
			2'd1: r = want_sin ? ca : -sa;
			2'd2: r = want_sin ? -sa : -ca;
			2'd3: r = want_sin ? -ca : sa;
			default: r = ca;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/spectral_band_energy_vad_unit.sv
// spectral_band_energy_vad_unit: top level, stream ports, config registers, result register
// depends on svad_pkg, svad_bandpow, svad_decide
//
// usage:
// samples arrive on the s_ channel, one signed 16-bit sample per transfer in s_tdata.
// every 512th sample completes a frame; the block then computes the band power of
// bins band_start_bin .. band_end_bin-1 and updates the speech decision, and one
// result transfer leaves on the m_ channel. other samples give no result.
// after the last sample of a frame, s_tready stays low while the band power and the
// decision are computed, longer when the background updates (the reset band has 44
// bins): one shared 32x28 multiplier does the cosine and sine products of each sample
// in turn over the 512-entry frame memory, and a shift-add divide by ten runs in the
// background update.
// the result sits in an output register until taken; samples keep flowing while it
// waits, but the last sample of the next frame is held off until m_tready takes it.
// config writes (cfg_we, cfg_index, cfg_data) take effect at once; write them only
// while idle. writing initial_threshold or initial_background also loads the live value.
// reset (arst_n low) restores all register defaults and empties the frame and history.
module spectral_band_energy_vad_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // sample[15:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_is_speech[0] speech_active[1] speech_began[2] speech_ended[3]
	// forward_frame[4] frame_slot[8:5] replay_first_slot[12:9] replay_count[16:13]
	// band_energy[64:17] silence_run[72:65] speech_run[88:73] zero[95:89]
	output logic [svad_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [svad_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [svad_pkg::CFG_DW-1:0]   cfg_data
);
	import svad_pkg::*;

	svad_cfg_t          cfg_q;
	svad_load_t         ld;
	logic [IDX_W-1:0]   idx_q;
	logic               busy_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_q;

	logic               s_xfer;
	logic               last_sample;
	logic               bp_done;
	logic [EN_W-1:0]    bp_energy;
	logic               dec_done;
	svad_res_t          res;
	logic [OUT_W-1:0]   packed_res;

	always_comb begin
		last_sample = idx_q == IDX_W'(FRAME_SAMPLES - 1);
		s_tready = !busy_q && !(last_sample && out_valid_q);
		s_xfer = s_tvalid && s_tready;
		ld.thr = cfg_we && cfg_index == REG_INIT_THR;
		ld.bg = cfg_we && cfg_index == REG_INIT_BG;
		ld.value = cfg_data[EN_W-1:0];
		packed_res = OUT_W'({res.speech_run, res.silence_run, res.band_energy,
			res.replay_count, res.replay_first_slot, res.frame_slot,
			res.forward_frame, res.speech_ended, res.speech_began,
			res.speech_active, res.frame_is_speech});
	end

	svad_bandpow u_bandpow (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (s_xfer),
		.wr_addr    (idx_q),
		.wr_data    ($signed(s_tdata)),
		.start      (s_xfer && last_sample),
		.band_start (cfg_q.band_start),
		.band_end   (cfg_q.band_end),
		.done       (bp_done),
		.energy     (bp_energy)
	);

	svad_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bp_done),
		.energy (bp_energy),
		.cfg    (cfg_q),
		.ld     (ld),
		.done   (dec_done),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_start <= BAND_START_RST;
			cfg_q.band_end <= BAND_END_RST;
			cfg_q.init_thr <= THR_RST;
			cfg_q.init_bg <= BG_RST;
			cfg_q.hangover <= HANGOVER_RST;
			cfg_q.warmup <= WARMUP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BAND_START: cfg_q.band_start <= cfg_data[BIN_W-1:0];
				REG_BAND_END: cfg_q.band_end <= cfg_data[BIN_W-1:0];
				REG_INIT_THR: cfg_q.init_thr <= cfg_data[EN_W-1:0];
				REG_INIT_BG: cfg_q.init_bg <= cfg_data[EN_W-1:0];
				REG_HANGOVER: cfg_q.hangover <= cfg_data[7:0];
				REG_WARMUP: cfg_q.warmup <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_xfer) begin
				idx_q <= idx_q + 1'b1;
				if (last_sample) begin
					busy_q <= 1'b1;
				end
			end
			if (dec_done) begin
				busy_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_done) begin
			out_q <= packed_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready)
		else $error("sample taken while a frame is being processed");
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_done |-> !out_valid_q)
		else $error("result overwrote a pending transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && last_sample) |=> busy_q)
		else $error("frame end did not start processing");
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_done |=> m_tvalid)
		else $error("finished result not presented");

endmodule

FILE: hw/rtl/svad_div10.sv
// svad_div10: divide by ten with a shift-add estimate and one remainder fix
// depends on svad_pkg
module svad_div10 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [svad_pkg::DIV_W-1:0] dividend,
	output logic                      done,
	output logic [svad_pkg::DIV_W-1:0] quotient
);
	import svad_pkg::*;

	localparam logic [2:0] V_IDLE = 3'd0;
	localparam logic [2:0] V_S4   = 3'd1;
	localparam logic [2:0] V_S8   = 3'd2;
	localparam logic [2:0] V_S16  = 3'd3;
	localparam logic [2:0] V_S32  = 3'd4;
	localparam logic [2:0] V_SH   = 3'd5;
	localparam logic [2:0] V_REM  = 3'd6;
	localparam logic [2:0] V_FIX  = 3'd7;

	logic [2:0]        st_q;
	logic              done_q;
	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  times10;

	always_comb begin
		times10 = {quo_q[DIV_W-4:0], 3'b000} + {quo_q[DIV_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= V_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				V_IDLE: begin
					if (start) begin
						st_q <= V_S4;
					end
				end
				V_S4, V_S8, V_S16, V_S32, V_SH, V_REM: st_q <= st_q + 1'b1;
				V_FIX: begin
					done_q <= 1'b1;
					st_q <= V_IDLE;
				end
				default: st_q <= V_IDLE;
			endcase
		end
	end

	// estimate 0.8 n / 8 from below, then one compare and subtract fixes it
	always_ff @(posedge clk) begin
		case (st_q)
			V_IDLE: begin
				if (start) begin
					num_q <= dividend;
					quo_q <= (dividend >> 1) + (dividend >> 2);
				end
			end
			V_S4: quo_q <= quo_q + (quo_q >> 4);
			V_S8: quo_q <= quo_q + (quo_q >> 8);
			V_S16: quo_q <= quo_q + (quo_q >> 16);
			V_S32: quo_q <= quo_q + (quo_q >> 32);
			V_SH: quo_q <= quo_q >> 3;
			V_REM: rem_q <= num_q - times10;
			V_FIX: begin
				if (rem_q >= DIV_W'(DIV_BY)) begin
					quo_q <= quo_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/svad_bandpow.sv
// svad_bandpow: frame store and band power over bins with one shared multiplier
// depends on svad_pkg
module svad_bandpow (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [svad_pkg::IDX_W-1:0]  wr_addr,
	input  logic signed [15:0]          wr_data,
	input  logic                        start,
	input  logic [svad_pkg::BIN_W-1:0]  band_start,
	input  logic [svad_pkg::BIN_W-1:0]  band_end,
	output logic                        done,
	output logic [svad_pkg::EN_W-1:0]   energy
);
	import svad_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BIN  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_MAG  = 3'd3;
	localparam logic [2:0] ST_SQ1  = 3'd4;
	localparam logic [2:0] ST_SQ2  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	localparam logic [1:0] PH_READ = 2'd0;
	localparam logic [1:0] PH_COS  = 2'd1;
	localparam logic [1:0] PH_SIN  = 2'd2;
	localparam logic [1:0] PH_IM   = 2'd3;

	localparam int LIM = FRAME_SAMPLES / 2 + 1;

	logic signed [15:0]        frame_mem [FRAME_SAMPLES];
	logic signed [15:0]        rd_q;
	logic [2:0]                st_q;
	logic [1:0]                ph_q;
	logic [BIN_W-1:0]          k_q;
	logic [IDX_W-1:0]          i_q;
	logic [IDX_W-1:0]          p_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   re_q;
	logic signed [ACC_W-1:0]   im_q;
	logic [RQ_W-1:0]           rq_q;
	logic [RQ_W-1:0]           iq_q;
	logic [PROD_W-1:0]         pw_q;
	logic [EN_W-1:0]           sum_q;

	logic [BIN_W-1:0]          end_eff;
	logic signed [31:0]        mul_a;
	logic signed [RQ_W:0]      mul_b;
	logic [ACC_W-1:0]          abs_re;
	logic [ACC_W-1:0]          abs_im;
	logic [ACC_W:0]            rnd_re;
	logic [ACC_W:0]            rnd_im;
	logic [PROD_W:0]           pw_sum;
	logic [EN_W:0]             sum_n;

	always_comb begin
		end_eff = (32'(band_end) > 32'(LIM)) ? BIN_W'(LIM) : band_end;
		if (st_q == ST_MAC) begin
			mul_a = tw_lookup(p_q, ph_q == PH_SIN);
			mul_b = (RQ_W+1)'(rd_q);
		end else if (st_q == ST_SQ2) begin
			mul_a = $signed(32'(iq_q));
			mul_b = $signed({1'b0, iq_q});
		end else begin
			mul_a = $signed(32'(rq_q));
			mul_b = $signed({1'b0, rq_q});
		end
		abs_re = re_q[ACC_W-1] ? ACC_W'(-re_q) : ACC_W'(re_q);
		abs_im = im_q[ACC_W-1] ? ACC_W'(-im_q) : ACC_W'(im_q);
		rnd_re = {1'b0, abs_re} + (ACC_W+1)'(1 << 29);
		rnd_im = {1'b0, abs_im} + (ACC_W+1)'(1 << 29);
		pw_sum = {1'b0, pw_q} + {1'b0, $unsigned(prod_q)} + (PROD_W+1)'(8192);
		sum_n = {1'b0, sum_q} + (EN_W+1)'(pw_sum >> 14);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		rd_q <= frame_mem[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_READ;
			k_q <= '0;
			i_q <= '0;
			p_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						k_q <= band_start;
						st_q <= ST_BIN;
					end
				end
				ST_BIN: begin
					if (k_q >= end_eff) begin
						st_q <= ST_DONE;
					end else begin
						i_q <= '0;
						p_q <= '0;
						ph_q <= PH_READ;
						st_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == PH_IM) begin
						i_q <= i_q + 1'b1;
						p_q <= p_q + IDX_W'(k_q);
						if (i_q == IDX_W'(FRAME_SAMPLES - 1)) begin
							st_q <= ST_MAG;
						end
					end
				end
				ST_MAG: st_q <= ST_SQ1;
				ST_SQ1: st_q <= ST_SQ2;
				ST_SQ2: st_q <= ST_ACC;
				ST_ACC: begin
					k_q <= k_q + 1'b1;
					st_q <= ST_BIN;
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (st_q == ST_IDLE && start) begin
			sum_q <= '0;
		end
		if (st_q == ST_BIN) begin
			re_q <= '0;
			im_q <= '0;
		end
		if (st_q == ST_MAC && ph_q == PH_SIN) begin
			re_q <= re_q + ACC_W'(prod_q);
		end
		if (st_q == ST_MAC && ph_q == PH_IM) begin
			im_q <= im_q + ACC_W'(prod_q);
		end
		if (st_q == ST_MAG) begin
			rq_q <= rnd_re[30 +: RQ_W];
			iq_q <= rnd_im[30 +: RQ_W];
		end
		if (st_q == ST_SQ2) begin
			pw_q <= $unsigned(prod_q);
		end
		if (st_q == ST_ACC) begin
			sum_q <= sum_n[EN_W] ? {EN_W{1'b1}} : sum_n[EN_W-1:0];
		end
	end

	assign done = (st_q == ST_DONE);
	assign energy = sum_q;

endmodule

FILE: hw/rtl/svad_decide.sv
// svad_decide: background tracking, threshold and speech/hangover sequencer
// depends on svad_pkg and svad_div10
module svad_decide (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [svad_pkg::EN_W-1:0] energy,
	input  svad_pkg::svad_cfg_t       cfg,
	input  svad_pkg::svad_load_t      ld,
	output logic                      done,
	output svad_pkg::svad_res_t       res
);
	import svad_pkg::*;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_CHK  = 2'd1;
	localparam logic [1:0] D_DIV  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]         st_q;
	logic [EN_W-1:0]    e_q;
	logic [EN_W-1:0]    bg_q;
	logic [EN_W-1:0]    thr_q;
	logic [7:0]         adapt_q;
	logic [7:0]         sil_q;
	logic [15:0]        spc_q;
	logic               ins_q;
	logic [HIST_W-1:0]  hws_q;
	logic [FILL_W-1:0]  fill_q;

	logic               e_ge;
	logic               below;
	logic [EN_W-1:0]    diff;
	logic [DIV_W-1:0]   dividend;
	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   quo;
	logic [EN_W-1:0]    bg_new;
	logic [7:0]         adapt_n;
	logic [EN_W-1:0]    thr2;

	logic               speech;
	logic [HIST_W-1:0]  hws_n;
	logic [FILL_W-1:0]  fill_n;
	logic [7:0]         sil_n;
	logic [15:0]        spc_n;
	logic               ins_n;
	logic               began;
	logic               ended;
	logic               skip;
	logic [HIST_W-1:0]  rfirst;
	logic [HIST_W-1:0]  rcount;

	always_comb begin
		e_ge = e_q >= bg_q;
		diff = e_ge ? (e_q - bg_q) : (bg_q - e_q);
		below = !e_ge || ({diff, 1'b0} < {1'b0, bg_q});
		dividend = DIV_W'(diff) + DIV_W'(DIV_BIAS);
		div_start = (st_q == D_CHK) && below;
		bg_new = e_ge ? EN_W'({1'b0, bg_q} + quo) : EN_W'({1'b0, bg_q} - quo);
		adapt_n = (adapt_q == 8'hFF) ? adapt_q : adapt_q + 1'b1;
		thr2 = bg_new[EN_W-1] ? {EN_W{1'b1}} : {bg_new[EN_W-2:0], 1'b0};
	end

	svad_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		speech = e_q > thr_q;
		hws_n = hws_q + 1'b1;
		fill_n = (fill_q == FILL_W'(HISTORY_FRAMES)) ? fill_q : fill_q + 1'b1;
		sil_n = sil_q;
		spc_n = spc_q;
		ins_n = ins_q;
		began = 1'b0;
		ended = 1'b0;
		skip = 1'b0;
		rfirst = '0;
		rcount = '0;
		if (speech) begin
			sil_n = '0;
			if (!ins_q) begin
				ins_n = 1'b1;
				began = 1'b1;
				if (fill_n <= FILL_W'(1)) begin
					skip = 1'b1;
				end else begin
					rcount = HIST_W'(fill_n - 1'b1);
					rfirst = hws_n - fill_n[HIST_W-1:0];
				end
			end
			if (!skip && spc_q != 16'hFFFF) begin
				spc_n = spc_q + 1'b1;
			end
		end else begin
			if (sil_q != 8'hFF) begin
				sil_n = sil_q + 1'b1;
			end
			spc_n = '0;
			if (ins_q && sil_n > cfg.hangover) begin
				ins_n = 1'b0;
				ended = 1'b1;
			end
		end
		res.frame_is_speech = speech;
		res.speech_active = ins_n;
		res.speech_began = began;
		res.speech_ended = ended;
		res.forward_frame = ins_n && !skip;
		res.frame_slot = hws_q;
		res.replay_first_slot = rfirst;
		res.replay_count = rcount;
		res.band_energy = e_q;
		res.silence_run = sil_n;
		res.speech_run = spc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			e_q <= '0;
			bg_q <= BG_RST;
			thr_q <= THR_RST;
			adapt_q <= '0;
			sil_q <= '0;
			spc_q <= '0;
			ins_q <= 1'b0;
			hws_q <= '0;
			fill_q <= '0;
		end else begin
			if (ld.thr) begin
				thr_q <= ld.value;
			end
			if (ld.bg) begin
				bg_q <= ld.value;
			end
			case (st_q)
				D_IDLE: begin
					if (start) begin
						e_q <= energy;
						st_q <= D_CHK;
					end
				end
				D_CHK: st_q <= below ? D_DIV : D_FIN;
				D_DIV: begin
					if (div_done) begin
						bg_q <= bg_new;
						adapt_q <= adapt_n;
						if (adapt_n > cfg.warmup) begin
							thr_q <= thr2;
						end
						st_q <= D_FIN;
					end
				end
				D_FIN: begin
					sil_q <= sil_n;
					spc_q <= spc_n;
					ins_q <= ins_n;
					hws_q <= hws_n;
					fill_q <= fill_n;
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	assign done = (st_q == D_FIN);

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == D_DIV)
		else $error("divider finished outside the update step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == D_FIN) |=> fill_q != '0)
		else $error("history fill stayed empty after a frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == D_FIN && speech) |=> sil_q == '0)
		else $error("silence run not cleared by a speech frame");

endmodule
